[hdl/deq_pkg.sv]
// types and constants shared by the double-ended queue modules
package deq_pkg;

  localparam logic [2:0] MODE_DUMP_FWD  = 3'd0;
  localparam logic [2:0] MODE_DUMP_REV  = 3'd1;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd2;
  localparam logic [2:0] MODE_PUSH_BACK = 3'd3;
  localparam logic [2:0] MODE_POP_FRONT = 3'd4;
  localparam logic [2:0] MODE_POP_BACK  = 3'd5;
  localparam logic [2:0] MODE_CLEAR     = 3'd6;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_DUMP_FWD,
    OP_DUMP_REV,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
    logic [4:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_t;

endpackage

[hdl/deq_front.sv]
// command intake: decodes each transfer and holds it in a two-entry queue
module deq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  deq_pkg::in_item_t in_item,
  output deq_pkg::cmdq_t   cmdq,
  input  logic             cmd_pop
);
  import deq_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  op_t        op_dec;

  always_comb begin
    unique case (in_item.mode)
      MODE_DUMP_FWD:   op_dec = OP_DUMP_FWD;
      MODE_DUMP_REV:   op_dec = OP_DUMP_REV;
      MODE_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      MODE_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      MODE_POP_FRONT:  op_dec = OP_POP_FRONT;
      MODE_POP_BACK:   op_dec = OP_POP_BACK;
      MODE_CLEAR:      op_dec = OP_CLEAR;
      default:         op_dec = OP_NOP;
    endcase
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign cmdq.valid = (cnt_r != 2'd0);
  assign cmdq.cmd   = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op_dec, value: in_item.value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

[hdl/deq_back.sv]
// command execution: ring storage, head and fill count, dump sequencing
module deq_back #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::cmdq_t     cmdq,
  output logic               cmd_pop,
  output logic               out_valid,
  output deq_pkg::out_item_t out_item
);
  import deq_pkg::*;

  localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = HW + 1;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dump_active_r, dump_active_nxt;
  logic          dump_rev_r, dump_rev_nxt;
  logic [HW-1:0] dump_pos_r, dump_pos_nxt;
  logic [CW-1:0] dump_rem_r, dump_rem_nxt;

  logic          res_valid_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          last_r, last_nxt;
  logic          use_mem_r, use_mem_nxt;
  logic [CW-1:0] occ_r;
  logic          out_valid_r;

  logic [HW-1:0] rd_addr;
  logic          wr_en;
  logic [HW-1:0] wr_addr;

  logic [SW-1:0] tail_sum, end_sum;
  logic [HW-1:0] tail_pos, end_pos;
  logic [HW-1:0] head_inc, head_dec, start_pos;
  logic [CW+4:0] occ_ext;

  function automatic logic [HW-1:0] ring_inc(input logic [HW-1:0] p);
    return (p == HW'(DEPTH - 1)) ? '0 : p + HW'(1);
  endfunction

  function automatic logic [HW-1:0] ring_dec(input logic [HW-1:0] p);
    return (p == '0) ? HW'(DEPTH - 1) : p - HW'(1);
  endfunction

  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r) - SW'(1);
    end_sum  = SW'(head_r) + SW'(count_r);
    tail_pos = (tail_sum >= SW'(DEPTH)) ? HW'(tail_sum - SW'(DEPTH)) : HW'(tail_sum);
    end_pos  = (end_sum >= SW'(DEPTH)) ? HW'(end_sum - SW'(DEPTH)) : HW'(end_sum);
    head_inc = ring_inc(head_r);
    head_dec = ring_dec(head_r);
  end

  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    dump_active_nxt = dump_active_r;
    dump_rev_nxt    = dump_rev_r;
    dump_pos_nxt    = dump_pos_r;
    dump_rem_nxt    = dump_rem_r;
    res_valid_nxt   = 1'b0;
    status_nxt      = STATUS_OK;
    last_nxt        = 1'b1;
    use_mem_nxt     = 1'b0;
    rd_addr         = dump_pos_r;
    wr_en           = 1'b0;
    wr_addr         = end_pos;
    cmd_pop         = 1'b0;
    start_pos       = head_r;

    if (dump_active_r) begin
      res_valid_nxt   = 1'b1;
      use_mem_nxt     = 1'b1;
      last_nxt        = (dump_rem_r == CW'(1));
      dump_rem_nxt    = dump_rem_r - CW'(1);
      dump_active_nxt = (dump_rem_r != CW'(1));
      dump_pos_nxt    = dump_rev_r ? ring_dec(dump_pos_r) : ring_inc(dump_pos_r);
    end else if (cmdq.valid) begin
      cmd_pop       = 1'b1;
      res_valid_nxt = 1'b1;
      unique case (cmdq.cmd.op)
        OP_DUMP_FWD, OP_DUMP_REV: begin
          if (count_r == '0) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            start_pos       = (cmdq.cmd.op == OP_DUMP_REV) ? tail_pos : head_r;
            rd_addr         = start_pos;
            use_mem_nxt     = 1'b1;
            last_nxt        = (count_r == CW'(1));
            dump_active_nxt = (count_r != CW'(1));
            dump_rev_nxt    = (cmdq.cmd.op == OP_DUMP_REV);
            dump_rem_nxt    = count_r - CW'(1);
            dump_pos_nxt    = (cmdq.cmd.op == OP_DUMP_REV) ? ring_dec(start_pos)
                                                          : ring_inc(start_pos);
          end
        end
        OP_PUSH_FRONT: begin
          if (count_r == CW'(DEPTH)) begin
            status_nxt = STATUS_FULL;
          end else begin
            head_nxt  = head_dec;
            wr_en     = 1'b1;
            wr_addr   = head_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (count_r == CW'(DEPTH)) begin
            status_nxt = STATUS_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = end_pos;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (count_r == '0) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (count_r == '0) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        OP_CLEAR: begin
          head_nxt = '0;
          if (count_r == '0) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            count_nxt = '0;
          end
        end
        default: begin
          status_nxt = STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmdq.cmd.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      count_r       <= '0;
      dump_active_r <= 1'b0;
      dump_rev_r    <= 1'b0;
      dump_pos_r    <= '0;
      dump_rem_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      dump_active_r <= dump_active_nxt;
      dump_rev_r    <= dump_rev_nxt;
      dump_pos_r    <= dump_pos_nxt;
      dump_rem_r    <= dump_rem_nxt;
      out_valid_r   <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    last_r    <= last_nxt;
    use_mem_r <= use_mem_nxt;
    occ_r     <= count_nxt;
  end

  assign occ_ext            = {5'b0, occ_r};
  assign out_valid          = out_valid_r;
  assign out_item.status    = status_r;
  assign out_item.element   = use_mem_r ? rd_data_r : 32'sd0;
  assign out_item.last      = last_r;
  assign out_item.occupancy = occ_ext[4:0];

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dump_active_r |-> (dump_rem_r != '0) && (dump_rem_r < count_r))
    else $error("dump remainder out of range");

  a_dump_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    dump_active_r |=> count_r == $past(count_r))
    else $error("fill count changed during dump");

  a_no_pop_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    dump_active_r |-> !cmd_pop)
    else $error("command taken during dump");
`endif

endmodule

[hdl/double_ended_queue.sv]
// top level of the bounded double-ended queue
// A command is taken when start is high and busy is low; busy rises only when
// two commands are waiting in the intake queue. Its result strobes on out_valid
// once the command has passed the intake queue and the executor's result
// register, and the receiver cannot stall it. Push, pop, clear and unused codes
// produce one result each and run at one command per cycle while no dump holds
// the executor. A dump produces one result per stored element (one result when
// empty), one per cycle from the single read port of the ring storage, and
// holds the executor until its last element is read; the last result of every
// command has last set. Storage needs no clearing after reset.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output deq_pkg::out_item_t out_item
);
  import deq_pkg::*;

  cmdq_t cmdq;
  logic  cmd_pop;

  deq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .cmdq    (cmdq),
    .cmd_pop (cmd_pop)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmdq      (cmdq),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
